>>> design/hsve_pkg.sv
// ----------------------------------------------------------------------------
// hsve_pkg
// Shared widths, reset values and register codes for the hsv to ws2812 spi
// encoder.
// ----------------------------------------------------------------------------
package hsve_pkg;

  localparam int unsigned ColorW        = 8;
  localparam int unsigned HueW          = 9;
  localparam int unsigned WordW         = 3 * ColorW;
  localparam int unsigned DefBitsPerLed = 24;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgOnePattern  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgZeroPattern = 1'd1;

  localparam logic [CfgDataW-1:0] OnePatternReset  = 8'd120;
  localparam logic [CfgDataW-1:0] ZeroPatternReset = 8'd96;

  localparam logic [0:0] CmdRgb = 1'b0;
  localparam logic [0:0] CmdHsv = 1'b1;

endpackage

>>> design/hsve_if.sv
// ----------------------------------------------------------------------------
// hsve_in_if / hsve_out_if
// Valid/ready channels for color beats in and encoded spi byte beats out.
// ----------------------------------------------------------------------------
interface hsve_in_if
  import hsve_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [HueW-1:0] hue;
  logic [ColorW-1:0] saturation;
  logic [ColorW-1:0] brightness;
  logic [ColorW-1:0] red;
  logic [ColorW-1:0] green;
  logic [ColorW-1:0] blue;

  modport source (output valid, cmd, hue, saturation, brightness, red, green, blue,
                  input ready);
  modport sink   (input valid, cmd, hue, saturation, brightness, red, green, blue,
                  output ready);
endinterface

interface hsve_out_if
  import hsve_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] spi_byte;
  logic              last;

  modport source (output valid, spi_byte, last, input ready);
  modport sink   (input valid, spi_byte, last, output ready);
endinterface

>>> design/hsve_color_pipe.sv
// ----------------------------------------------------------------------------
// hsve_color_pipe
// Five stage pipeline turning a color beat (rgb or hsv) into the 24-bit
// green:red:blue word, with per-stage valid bits and stall propagation.
// ----------------------------------------------------------------------------
module hsve_color_pipe
  import hsve_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  hsve_in_if.sink          in_i,
  output logic             word_valid_o,
  input  logic             word_ready_i,
  output logic [WordW-1:0] word_o
);

  localparam logic [HueW-1:0] Deg360 = 9'd360;

  logic [4:0] valid_q;
  logic [4:0] en;

  // stage 1
  logic              s1_cmd_q;
  logic [WordW-1:0]  s1_rgb_q;
  logic [ColorW-1:0] s1_v_q;
  logic [2:0]        s1_sector_q;
  logic [5:0]        s1_rem_q;
  logic [15:0]       s1_prod_q;
  // stage 2
  logic              s2_cmd_q;
  logic [WordW-1:0]  s2_rgb_q;
  logic [ColorW-1:0] s2_v_q;
  logic [2:0]        s2_sector_q;
  logic [ColorW-1:0] s2_c_q;
  logic [6:0]        s2_rsel_q;
  // stage 3
  logic              s3_cmd_q;
  logic [WordW-1:0]  s3_rgb_q;
  logic [2:0]        s3_sector_q;
  logic [ColorW-1:0] s3_c_q;
  logic [ColorW-1:0] s3_m_q;
  logic [14:0]       s3_prod_q;
  // stage 4
  logic              s4_cmd_q;
  logic [WordW-1:0]  s4_rgb_q;
  logic [2:0]        s4_sector_q;
  logic [ColorW-1:0] s4_c_q;
  logic [ColorW-1:0] s4_m_q;
  logic [ColorW-1:0] s4_x_q;
  // stage 5
  logic [WordW-1:0]  s5_word_q;

  logic [HueW-1:0]   hue_wrap;
  logic [2:0]        sector;
  logic [HueW-1:0]   sector_base;
  logic [HueW-1:0]   rem_full;
  logic [16:0]       div255_sum;
  logic [29:0]       div60_prod;
  logic [ColorW-1:0] ch_r;
  logic [ColorW-1:0] ch_g;
  logic [ColorW-1:0] ch_b;
  logic [ColorW:0]   sum_c;
  logic [ColorW:0]   sum_x;
  logic [ColorW-1:0] sat_c;
  logic [ColorW-1:0] sat_x;
  logic [WordW-1:0]  word_d;

  assign en[4] = !valid_q[4] || word_ready_i;
  assign en[3] = !valid_q[3] || en[4];
  assign en[2] = !valid_q[2] || en[3];
  assign en[1] = !valid_q[1] || en[2];
  assign en[0] = !valid_q[0] || en[1];

  assign in_i.ready   = en[0];
  assign word_valid_o = valid_q[4];
  assign word_o       = s5_word_q;

  // hue wrap and sector split
  always_comb begin
    hue_wrap = (in_i.hue >= Deg360) ? in_i.hue - Deg360 : in_i.hue;
    if (hue_wrap >= 9'd300) begin
      sector = 3'd5; sector_base = 9'd300;
    end else if (hue_wrap >= 9'd240) begin
      sector = 3'd4; sector_base = 9'd240;
    end else if (hue_wrap >= 9'd180) begin
      sector = 3'd3; sector_base = 9'd180;
    end else if (hue_wrap >= 9'd120) begin
      sector = 3'd2; sector_base = 9'd120;
    end else if (hue_wrap >= 9'd60) begin
      sector = 3'd1; sector_base = 9'd60;
    end else begin
      sector = 3'd0; sector_base = 9'd0;
    end
    rem_full = hue_wrap - sector_base;
  end

  // floor(p/255) for p up to 255*255
  assign div255_sum = {1'b0, s1_prod_q} + 17'd1 + {9'd0, s1_prod_q[15:8]};

  // floor(n/60) by reciprocal, exact for n up to 255*60
  assign div60_prod = {15'd0, s3_prod_q} * 30'd17477;

  always_comb begin
    sum_c = {1'b0, s4_m_q} + {1'b0, s4_c_q};
    sum_x = {1'b0, s4_m_q} + {1'b0, s4_x_q};
    sat_c = sum_c[ColorW] ? {ColorW{1'b1}} : sum_c[ColorW-1:0];
    sat_x = sum_x[ColorW] ? {ColorW{1'b1}} : sum_x[ColorW-1:0];
    ch_r  = s4_m_q;
    ch_g  = s4_m_q;
    ch_b  = s4_m_q;
    case (s4_sector_q)
      3'd0: begin ch_r = sat_c; ch_g = sat_x; end
      3'd1: begin ch_g = sat_c; ch_r = sat_x; end
      3'd2: begin ch_g = sat_c; ch_b = sat_x; end
      3'd3: begin ch_b = sat_c; ch_g = sat_x; end
      3'd4: begin ch_b = sat_c; ch_r = sat_x; end
      3'd5: begin ch_r = sat_c; ch_b = sat_x; end
      default: begin end
    endcase
    if (s4_cmd_q == CmdHsv) begin
      word_d = {ch_g, ch_r, ch_b};
    end else begin
      word_d = s4_rgb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_i.valid;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
      if (en[3]) valid_q[3] <= valid_q[2];
      if (en[4]) valid_q[4] <= valid_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_cmd_q    <= in_i.cmd;
      s1_rgb_q    <= {in_i.green, in_i.red, in_i.blue};
      s1_v_q      <= in_i.brightness;
      s1_sector_q <= sector;
      s1_rem_q    <= rem_full[5:0];
      s1_prod_q   <= {8'd0, in_i.brightness} * {8'd0, in_i.saturation};
    end
    if (en[1]) begin
      s2_cmd_q    <= s1_cmd_q;
      s2_rgb_q    <= s1_rgb_q;
      s2_v_q      <= s1_v_q;
      s2_sector_q <= s1_sector_q;
      s2_c_q      <= div255_sum[15:8];
      s2_rsel_q   <= s1_sector_q[0] ? 7'd60 - {1'b0, s1_rem_q} : {1'b0, s1_rem_q};
    end
    if (en[2]) begin
      s3_cmd_q    <= s2_cmd_q;
      s3_rgb_q    <= s2_rgb_q;
      s3_sector_q <= s2_sector_q;
      s3_c_q      <= s2_c_q;
      s3_m_q      <= s2_v_q - s2_c_q;
      s3_prod_q   <= {7'd0, s2_c_q} * {8'd0, s2_rsel_q};
    end
    if (en[3]) begin
      s4_cmd_q    <= s3_cmd_q;
      s4_rgb_q    <= s3_rgb_q;
      s4_sector_q <= s3_sector_q;
      s4_c_q      <= s3_c_q;
      s4_m_q      <= s3_m_q;
      s4_x_q      <= div60_prod[27:20];
    end
    if (en[4]) begin
      s5_word_q   <= word_d;
    end
  end

endmodule

>>> design/hsve_serializer.sv
// ----------------------------------------------------------------------------
// hsve_serializer
// Shifts the color word out msb first, one encoded spi byte beat per bit,
// padding with the zero pattern and flagging the final beat.
// ----------------------------------------------------------------------------
module hsve_serializer
  import hsve_pkg::*;
#(
  parameter int unsigned BITS_PER_LED = DefBitsPerLed
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                word_valid_i,
  output logic                word_ready_o,
  input  logic [WordW-1:0]    word_i,
  input  logic [CfgDataW-1:0] one_pattern_i,
  input  logic [CfgDataW-1:0] zero_pattern_i,
  hsve_out_if.source          out_o
);

  localparam int unsigned CntW = $clog2(BITS_PER_LED + 1);
  localparam logic [CntW-1:0] CntLoad = CntW'(BITS_PER_LED - 1);

  logic [WordW-1:0]  shift_d, shift_q;
  logic [CntW-1:0]   left_d, left_q;
  logic              valid_d, valid_q;
  logic [ColorW-1:0] byte_d, byte_q;
  logic              last_d, last_q;
  logic              advance;

  assign advance      = !valid_q || out_o.ready;
  assign word_ready_o = advance && (left_q == '0);

  assign out_o.valid    = valid_q;
  assign out_o.spi_byte = byte_q;
  assign out_o.last     = last_q;

  always_comb begin
    shift_d = shift_q;
    left_d  = left_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (advance) begin
      if (left_q != '0) begin
        byte_d  = shift_q[WordW-1] ? one_pattern_i : zero_pattern_i;
        last_d  = (left_q == CntW'(1));
        shift_d = {shift_q[WordW-2:0], 1'b0};
        left_d  = left_q - CntW'(1);
        valid_d = 1'b1;
      end else if (word_valid_i) begin
        byte_d  = word_i[WordW-1] ? one_pattern_i : zero_pattern_i;
        last_d  = (CntLoad == '0);
        shift_d = {word_i[WordW-2:0], 1'b0};
        left_d  = CntLoad;
        valid_d = 1'b1;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= '0;
      shift_q <= '0;
    end else begin
      valid_q <= valid_d;
      left_q  <= left_d;
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

endmodule

>>> design/hsv_to_ws2812_spi_encoder.sv
// ----------------------------------------------------------------------------
// hsv_to_ws2812_spi_encoder
// Color beats (rgb or hsv) in, BITS_PER_LED encoded spi byte beats out per color.
// A color beat passes the 5 pipe stages and then the serializer byte register.
// Throughput: one byte beat per cycle unless out_o stalls; the color pipe takes a
// beat a cycle unless stalled; the serializer loads the next color with its last beat.
// Reset: clears all valid bits and the bit counter; one/zero patterns to 120/96.
// ----------------------------------------------------------------------------
module hsv_to_ws2812_spi_encoder
  import hsve_pkg::*;
#(
  parameter int unsigned BITS_PER_LED = DefBitsPerLed
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  hsve_in_if.sink             in_i,
  hsve_out_if.source          out_o
);

  logic [CfgDataW-1:0] one_pattern_q;
  logic [CfgDataW-1:0] zero_pattern_q;
  logic                word_valid;
  logic                word_ready;
  logic [WordW-1:0]    word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_pattern_q  <= OnePatternReset;
      zero_pattern_q <= ZeroPatternReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOnePattern:  one_pattern_q  <= cfg_data_i;
        CfgZeroPattern: zero_pattern_q <= cfg_data_i;
        default: begin end
      endcase
    end
  end

  hsve_color_pipe u_color_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .word_valid_o (word_valid),
    .word_ready_i (word_ready),
    .word_o       (word)
  );

  hsve_serializer #(
    .BITS_PER_LED (BITS_PER_LED)
  ) u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .word_valid_i   (word_valid),
    .word_ready_o   (word_ready),
    .word_i         (word),
    .one_pattern_i  (one_pattern_q),
    .zero_pattern_i (zero_pattern_q),
    .out_o          (out_o)
  );

endmodule

>>> verif/tb_hsv_to_ws2812_spi_encoder.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_ws2812_spi_encoder
// Drives rgb and hsv color beats into the encoder and checks every spi byte beat
// against the table's known word or a local hsv to grb converter, and a bit encoder.
// It starts with a directed table of edge colors, then random colors under several
// pattern settings, with random idle bursts on both channels save in the last one.
// ----------------------------------------------------------------------------
module tb_hsv_to_ws2812_spi_encoder;
  import hsve_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandPerPhase = 22;
  localparam int unsigned NumRows      = 24;

  typedef struct packed {
    logic              cmd;
    logic [HueW-1:0]   hue;
    logic [ColorW-1:0] saturation;
    logic [ColorW-1:0] brightness;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } color_req_t;

  typedef struct packed {
    color_req_t       req;
    logic             known;
    logic [WordW-1:0] word;
  } color_row_t;

  typedef struct packed {
    logic [ColorW-1:0] spi_byte;
    logic              last;
  } spi_beat_t;

  // known word is green:red:blue
  localparam color_row_t DirectedRows [NumRows] = '{
    '{'{CmdRgb, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 24'h000000},
    '{'{CmdRgb, 9'd0,   8'h00, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1, 24'hffffff},
    '{'{CmdRgb, 9'd0,   8'h00, 8'h00, 8'hff, 8'h00, 8'h00}, 1'b1, 24'h00ff00},
    '{'{CmdRgb, 9'd0,   8'h00, 8'h00, 8'h00, 8'hff, 8'h00}, 1'b1, 24'hff0000},
    '{'{CmdRgb, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 8'hff}, 1'b1, 24'h0000ff},
    '{'{CmdRgb, 9'd511, 8'hff, 8'hff, 8'ha5, 8'h5a, 8'hc3}, 1'b1, 24'h5aa5c3},
    '{'{CmdHsv, 9'd0,   8'h00, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1, 24'h000000},
    '{'{CmdHsv, 9'd0,   8'h00, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, 24'hffffff},
    '{'{CmdHsv, 9'd0,   8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, 24'h00ff00},
    '{'{CmdHsv, 9'd120, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, 24'hff0000},
    '{'{CmdHsv, 9'd240, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, 24'h0000ff},
    '{'{CmdHsv, 9'd60,  8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, 24'hffff00},
    '{'{CmdHsv, 9'd180, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, 24'hff00ff},
    '{'{CmdHsv, 9'd300, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, 24'h00ffff},
    '{'{CmdHsv, 9'd359, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h000000},
    '{'{CmdHsv, 9'd360, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, 24'h00ff00},
    '{'{CmdHsv, 9'd511, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h000000},
    '{'{CmdHsv, 9'd420, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, 24'hffff00},
    '{'{CmdHsv, 9'd30,  8'h80, 8'hc8, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h000000},
    '{'{CmdHsv, 9'd90,  8'hff, 8'h80, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h000000},
    '{'{CmdHsv, 9'd210, 8'h01, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h000000},
    '{'{CmdHsv, 9'd0,   8'hff, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1, 24'h000000},
    '{'{CmdHsv, 9'd256, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h000000},
    '{'{CmdRgb, 9'd0,   8'h00, 8'h00, 8'h01, 8'h80, 8'h7f}, 1'b1, 24'h80017f}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  hsve_in_if  in_if ();
  hsve_out_if out_if ();

  hsv_to_ws2812_spi_encoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [ColorW-1:0] one_pat = OnePatternReset;
  logic [ColorW-1:0] zero_pat = ZeroPatternReset;
  spi_beat_t         due_bytes [$];
  spi_beat_t         want;
  bit                idle_on = 1'b1;
  int unsigned       stall_left = 0;
  int unsigned       errors = 0;
  int unsigned       beats_checked = 0;
  int unsigned       colors_sent = 0;
  int unsigned       hsv_sent = 0;
  int unsigned       cycle_count = 0;

  function automatic int unsigned clamp_255(int unsigned v);
    return (v > 255) ? 255 : v;
  endfunction

  function automatic logic [WordW-1:0] grb_for(color_req_t req);
    int unsigned h, s, v, sector, rem, c, x, m, r, g, b;
    if (req.cmd == CmdRgb) return {req.green, req.red, req.blue};
    h = req.hue;
    s = req.saturation;
    v = req.brightness;
    if (h >= 360) h -= 360;
    sector = h / 60;
    rem = h % 60;
    c = (v * s) / 255;
    x = (sector % 2 == 0) ? (c * rem) / 60 : (c * (60 - rem)) / 60;
    m = v - c;
    r = m;
    g = m;
    b = m;
    case (sector)
      0: begin r += c; g += x; end
      1: begin g += c; r += x; end
      2: begin g += c; b += x; end
      3: begin b += c; g += x; end
      4: begin b += c; r += x; end
      default: begin r += c; b += x; end
    endcase
    return {ColorW'(clamp_255(g)), ColorW'(clamp_255(r)), ColorW'(clamp_255(b))};
  endfunction

  function automatic logic [ColorW-1:0] rand_level();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return ColorW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic color_req_t rand_color();
    color_req_t req;
    req.cmd = $urandom_range(0, 1) ? CmdHsv : CmdRgb;
    req.hue = ($urandom_range(0, 7) == 0) ? HueW'($urandom_range(360, 511))
                                          : HueW'($urandom_range(0, 359));
    req.saturation = rand_level();
    req.brightness = rand_level();
    req.red = rand_level();
    req.green = rand_level();
    req.blue = rand_level();
    return req;
  endfunction

  task automatic send_color(color_req_t req, logic known, logic [WordW-1:0] word);
    logic [WordW-1:0] grb;
    logic             bit_val;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= req.cmd;
    in_if.hue        <= req.hue;
    in_if.saturation <= req.saturation;
    in_if.brightness <= req.brightness;
    in_if.red        <= req.red;
    in_if.green      <= req.green;
    in_if.blue       <= req.blue;
    do @(posedge clk_i); while (!in_if.ready);
    grb = known ? word : grb_for(req);
    for (int k = 0; k < DefBitsPerLed; k++) begin
      bit_val = (k < WordW) ? grb[WordW-1-k] : 1'b0;
      due_bytes.push_back(spi_beat_t'{bit_val ? one_pat : zero_pat,
                                      k == DefBitsPerLed - 1});
    end
    colors_sent++;
    if (req.cmd == CmdHsv) hsv_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgOnePattern) one_pat = data;
    else zero_pat = data;
  endtask

  task automatic wait_drained();
    while (due_bytes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_bytes.size() == 0) begin
        $display("%0t: unexpected beat spi_byte=%h last=%b",
                 $time, out_if.spi_byte, out_if.last);
        errors++;
      end else begin
        want = due_bytes.pop_front();
        beats_checked++;
        if (out_if.spi_byte !== want.spi_byte) begin
          $display("%0t: spi_byte expected %h actual %h", $time, want.spi_byte,
                   out_if.spi_byte);
          errors++;
        end
        if (out_if.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_if.last);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
               due_bytes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.cmd        = CmdRgb;
    in_if.hue        = '0;
    in_if.saturation = '0;
    in_if.brightness = '0;
    in_if.red        = '0;
    in_if.green      = '0;
    in_if.blue       = '0;
    out_if.ready     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      send_color(DirectedRows[i].req, DirectedRows[i].known, DirectedRows[i].word);
    end

    for (int p = 0; p < 4; p++) begin
      in_if.valid <= 1'b0;
      wait_drained();
      case (p)
        0: begin write_reg(CfgOnePattern, 8'hff); write_reg(CfgZeroPattern, 8'h00); end
        1: begin write_reg(CfgOnePattern, 8'h00); write_reg(CfgZeroPattern, 8'hff); end
        2: begin
          write_reg(CfgZeroPattern, CfgDataW'($urandom_range(0, 255)));
          write_reg(CfgOnePattern, CfgDataW'($urandom_range(0, 255)));
        end
        default: begin
          write_reg(CfgOnePattern, 8'hf0);
          write_reg(CfgZeroPattern, 8'hc0);
          idle_on = 1'b0;
        end
      endcase
      for (int i = 0; i < RandPerPhase; i++) send_color(rand_color(), 1'b0, '0);
    end
    in_if.valid <= 1'b0;
    wait_drained();

    if (due_bytes.size() != 0) begin
      $display("%0t: %0d bytes never arrived", $time, due_bytes.size());
      errors++;
    end
    $display("sent %0d colors (%0d hsv, %0d rgb) over 5 pattern settings",
             colors_sent, hsv_sent, colors_sent - hsv_sent);
    $display("checked %0d spi byte beats, %0d mismatches", beats_checked, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
design/hsve_pkg.sv
design/hsve_if.sv
design/hsve_color_pipe.sv
design/hsve_serializer.sv
design/hsv_to_ws2812_spi_encoder.sv
verif/tb_hsv_to_ws2812_spi_encoder.sv
